/* rtl/core/gba_pkg.sv */
package gba_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned KEY_W          = 32;
  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned CFG_DATA_W     = 32;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CODE_W         = 3;

  typedef enum logic [CODE_W-1:0] {
    AGG_SUM   = 3'd0,
    AGG_MAX   = 3'd1,
    AGG_MIN   = 3'd2,
    AGG_COUNT = 3'd3,
    AGG_AVG   = 3'd4
  } agg_func_e;

  typedef enum logic [CODE_W-1:0] {
    CMP_LT = 3'd0,
    CMP_GT = 3'd1,
    CMP_GE = 3'd2,
    CMP_LE = 3'd3,
    CMP_EQ = 3'd4,
    CMP_NE = 3'd5
  } cmp_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HAVING_FUNC = 2'd0,
    CFG_RETURN_FUNC = 2'd1,
    CFG_COMPARE_OP  = 2'd2,
    CFG_THRESHOLD   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CLOSE,
    ST_DIV,
    ST_EMIT,
    ST_ABSORB
  } ctrl_state_e;

  typedef struct packed {
    logic load_in;
    logic absorb;
    logic start_div;
    logic emit;
    logic emit_done;
    logic close_group;
  } gba_cmd_t;

  typedef struct packed {
    logic key_change;
    logic need_avg;
    logic div_done;
    logic pass;
    logic out_free;
    logic in_end;
  } gba_status_t;

endpackage

/* rtl/core/gba_div.sv */
module gba_div #(
  parameter int unsigned DW = gba_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic        [DW-1:0] divisor_i,
  output logic                 done_o,
  output logic signed [DW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DW + 1);

  logic            busy_q, fin_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DW:0]     rem_q;
  logic [DW-1:0]   quo_q, dsr_q, mag;
  logic            neg_q;
  logic signed [DW-1:0] res_q;

  logic [DW:0] rem_sh, diff;
  logic        ge;

  assign mag    = dividend_i[DW-1] ? (~dividend_i + DW'(1)) : dividend_i;
  assign rem_sh = {rem_q[DW-1:0], quo_q[DW-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};
  assign ge     = ~diff[DW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(DW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Restoring division on magnitudes; the sign is put back in the final cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= mag;
      dsr_q <= divisor_i;
      neg_q <= dividend_i[DW-1];
    end else if (busy_q) begin
      rem_q <= ge ? diff : rem_sh;
      quo_q <= {quo_q[DW-2:0], ge};
    end else if (fin_q) begin
      res_q <= neg_q ? $signed(~quo_q + DW'(1)) : $signed(quo_q);
    end
  end

  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

/* rtl/core/gba_datapath.sv */
module gba_datapath #(
  parameter int unsigned DW = gba_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gba_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gba_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic signed [gba_pkg::KEY_W-1:0]    group_key_i,
  input  logic signed [gba_pkg::FIELD_W-1:0]  row_value_i,
  input  logic                                end_of_table_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [gba_pkg::KEY_W-1:0]    out_key_o,
  output logic signed [gba_pkg::FIELD_W-1:0]  out_value_o,
  output logic                                row_valid_o,
  output logic                                stream_done_o,
  output logic                                last_of_run_o,
  input  gba_pkg::gba_cmd_t                   cmd_i,
  output gba_pkg::gba_status_t                status_o
);

  import gba_pkg::*;

  localparam int unsigned CW = ((DW > FIELD_W) ? DW : FIELD_W) + 1;
  localparam logic [DW-1:0] CntMax = DW'((64'(1) << (DW - 1)) - 64'(1));

  // Configuration registers.
  logic [CODE_W-1:0]            hav_func_q, ret_func_q, cmp_op_q;
  logic signed [CFG_DATA_W-1:0] thr_q;

  // Captured input row.
  logic signed [KEY_W-1:0] key_q;
  logic signed [DW-1:0]    val_q;
  logic                    end_q;

  // Open group.
  logic                    group_open_q;
  logic signed [KEY_W-1:0] cur_key_q;
  logic signed [DW-1:0]    sum_q, max_q, min_q;
  logic        [DW-1:0]    cnt_q;

  // Output register.
  logic                      out_valid_q, row_valid_q, done_q, last_q;
  logic signed [KEY_W-1:0]   out_key_q;
  logic signed [FIELD_W-1:0] out_value_q;

  logic                 div_done;
  logic signed [DW-1:0] avg;
  logic signed [CW-1:0] hav_agg, ret_agg, thr;
  logic                 pass;

  gba_div #(
    .DW(DW)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (cmd_i.start_div),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (avg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hav_func_q <= '0;
      ret_func_q <= '0;
      cmp_op_q   <= '0;
      thr_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HAVING_FUNC: hav_func_q <= cfg_data_i[CODE_W-1:0];
        CFG_RETURN_FUNC: ret_func_q <= cfg_data_i[CODE_W-1:0];
        CFG_COMPARE_OP:  cmp_op_q   <= cfg_data_i[CODE_W-1:0];
        CFG_THRESHOLD:   thr_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      key_q <= group_key_i;
      val_q <= DW'(row_value_i);
      end_q <= end_of_table_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_open_q <= 1'b0;
    end else if (cmd_i.close_group) begin
      group_open_q <= 1'b0;
    end else if (cmd_i.absorb) begin
      group_open_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb) begin
      if (!group_open_q) begin
        cur_key_q <= key_q;
        sum_q     <= val_q;
        max_q     <= val_q;
        min_q     <= val_q;
        cnt_q     <= DW'(1);
      end else begin
        sum_q <= sum_q + val_q;
        if (val_q > max_q) begin
          max_q <= val_q;
        end
        if (val_q < min_q) begin
          min_q <= val_q;
        end
        if (cnt_q < CntMax) begin
          cnt_q <= cnt_q + DW'(1);
        end
      end
    end
  end

  always_comb begin
    case (hav_func_q)
      AGG_SUM:   hav_agg = CW'(sum_q);
      AGG_MAX:   hav_agg = CW'(max_q);
      AGG_MIN:   hav_agg = CW'(min_q);
      AGG_COUNT: hav_agg = $signed(CW'(cnt_q));
      AGG_AVG:   hav_agg = CW'(avg);
      default:   hav_agg = '0;
    endcase
    case (ret_func_q)
      AGG_SUM:   ret_agg = CW'(sum_q);
      AGG_MAX:   ret_agg = CW'(max_q);
      AGG_MIN:   ret_agg = CW'(min_q);
      AGG_COUNT: ret_agg = $signed(CW'(cnt_q));
      AGG_AVG:   ret_agg = CW'(avg);
      default:   ret_agg = '0;
    endcase
  end

  assign thr = CW'(thr_q);

  always_comb begin
    case (cmp_op_q)
      CMP_LT:  pass = hav_agg <  thr;
      CMP_GT:  pass = hav_agg >  thr;
      CMP_GE:  pass = hav_agg >= thr;
      CMP_LE:  pass = hav_agg <= thr;
      CMP_EQ:  pass = hav_agg == thr;
      CMP_NE:  pass = hav_agg != thr;
      default: pass = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // A failing group still reports on the end row, with zero key and value.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      row_valid_q <= pass;
      done_q      <= cmd_i.emit_done;
      last_q      <= cmd_i.emit_done | ~end_q;
      out_key_q   <= pass ? cur_key_q : '0;
      out_value_q <= pass ? ret_agg[FIELD_W-1:0] : '0;
    end
  end

  assign status_o.key_change = group_open_q && (key_q != cur_key_q);
  assign status_o.need_avg   = (hav_func_q == AGG_AVG) || (ret_func_q == AGG_AVG);
  assign status_o.div_done   = div_done;
  assign status_o.pass       = pass;
  assign status_o.out_free   = ~out_valid_q | out_ready_i;
  assign status_o.in_end     = end_q;

  assign out_valid_o   = out_valid_q;
  assign out_key_o     = out_key_q;
  assign out_value_o   = out_value_q;
  assign row_valid_o   = row_valid_q;
  assign stream_done_o = done_q;
  assign last_of_run_o = last_q;

`ifndef ASSERT_OFF
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    group_open_q |-> (cnt_q != '0) && (cnt_q <= CntMax))
    else $error("row count out of range in an open group");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    group_open_q |-> (min_q <= max_q))
    else $error("running minimum above running maximum");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !row_valid_q) |-> (out_key_q == '0) && (out_value_q == '0))
    else $error("non-passing result carries data");

  a_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.emit_done) |=> !group_open_q)
    else $error("group still open after end of table");
`endif

endmodule

/* rtl/core/gba_ctrl.sv */
module gba_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gba_pkg::gba_status_t status_i,
  output gba_pkg::gba_cmd_t    cmd_o
);

  import gba_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        closing_end_q, closing_end_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      closing_end_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      closing_end_q <= closing_end_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    closing_end_d = closing_end_q;
    case (state_q)
      ST_IDLE: begin
        closing_end_d = 1'b0;
        if (in_valid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = status_i.key_change ? ST_CLOSE : ST_ABSORB;
      end
      ST_CLOSE: begin
        state_d = status_i.need_avg ? ST_DIV : ST_EMIT;
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (closing_end_q) begin
          if (status_i.out_free) begin
            state_d = ST_IDLE;
          end
        end else if (!status_i.pass || status_i.out_free) begin
          state_d = ST_ABSORB;
        end
      end
      ST_ABSORB: begin
        if (status_i.in_end) begin
          closing_end_d = 1'b1;
          state_d       = ST_CLOSE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_CLOSE: begin
        cmd_o.start_div = status_i.need_avg;
      end
      ST_EMIT: begin
        // On a key change a failing group is dropped without a transfer.
        if (closing_end_q) begin
          cmd_o.emit        = status_i.out_free;
          cmd_o.emit_done   = status_i.out_free;
          cmd_o.close_group = status_i.out_free;
        end else if (!status_i.pass) begin
          cmd_o.close_group = 1'b1;
        end else begin
          cmd_o.emit        = status_i.out_free;
          cmd_o.close_group = status_i.out_free;
        end
      end
      ST_ABSORB: begin
        cmd_o.absorb = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/group_by_having_aggregator.sv */
// A row that closes no group passes the idle, check and absorb states before the next transfer.
// Closing a group adds the close and emit states, and the divide state while the serial divider
// forms an average; an end row that also changes the key closes two groups.
// Throughput is one row at a time; a result waits in the output register while the next row
// runs, and a second result stalls the row until the first one has been taken.
// Reset (rst_ni low, asynchronous) clears the registers to sum, compare less, threshold 0,
// and leaves no group open and no result pending.
module group_by_having_aggregator #(
  parameter int unsigned DATA_WIDTH = gba_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gba_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [gba_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [gba_pkg::KEY_W-1:0]    group_key_i,
  input  logic signed [gba_pkg::FIELD_W-1:0]  row_value_i,
  input  logic                                end_of_table_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [gba_pkg::KEY_W-1:0]    out_key_o,
  output logic signed [gba_pkg::FIELD_W-1:0]  out_value_o,
  output logic                                row_valid_o,
  output logic                                stream_done_o,
  output logic                                last_of_run_o
);

  import gba_pkg::*;

  gba_cmd_t    cmd;
  gba_status_t status;

  gba_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .status_i (status),
    .cmd_o    (cmd)
  );

  gba_datapath #(
    .DW(DATA_WIDTH)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .group_key_i,
    .row_value_i,
    .end_of_table_i,
    .out_valid_o,
    .out_ready_i,
    .out_key_o,
    .out_value_o,
    .row_valid_o,
    .stream_done_o,
    .last_of_run_o,
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule
